// ===== design/gpfe_pkg.sv =====
package gpfe_pkg;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_SKIP2 = 3'd2,
    PH_LAT   = 3'd3,
    PH_GAP   = 3'd4,
    PH_LON   = 3'd5
  } phase_t;

  localparam logic [7:0] HDR_LEN     = 8'd6;
  localparam logic [7:0] FRAME_LEN_RST = 8'd65;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_N        = 8'h4E;
  localparam logic [7:0] CH_E        = 8'h45;
  localparam logic [7:0] CNT_MAX     = 8'hFF;

  localparam logic       LINE_LAT    = 1'b0;
  localparam logic       LINE_LON    = 1'b1;

  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic       line;
    logic       last;
  } res_t;

  // "$GPGGA"
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h24;
      3'd1:    b = 8'h47;
      3'd2:    b = 8'h50;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h47;
      3'd5:    b = 8'h41;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/gpfe_parser.sv =====
module gpfe_parser
  import gpfe_pkg::*;
(
  input  phase_t     phase,
  input  logic [7:0] byte_count,
  input  logic [7:0] rx_byte,
  input  logic [7:0] frame_length,
  output phase_t     phase_nxt,
  output logic [7:0] count_nxt,
  output res_t       res
);

  logic [7:0] cnt_inc;
  logic       hdr_hit;
  logic       done;
  phase_t     ph_step;
  logic [7:0] cnt_step;
  logic       chk_len;

  assign cnt_inc = (byte_count == CNT_MAX) ? byte_count : byte_count + 8'd1;
  assign hdr_hit = (byte_count < HDR_LEN) && (rx_byte == hdr_byte(byte_count[2:0]));

  always_comb begin
    ph_step  = phase;
    cnt_step = cnt_inc;
    chk_len  = 1'b1;
    done     = 1'b0;
    res      = '0;
    case (phase)
      PH_SKIP1: begin
        if (rx_byte == CH_COMMA) ph_step = PH_SKIP2;
      end
      PH_SKIP2: begin
        if (rx_byte == CH_COMMA) ph_step = PH_LAT;
      end
      PH_LAT: begin
        res.vld  = 1'b1;
        res.ch   = rx_byte;
        res.line = LINE_LAT;
        res.last = (rx_byte == CH_N);
        if (rx_byte == CH_N) ph_step = PH_GAP;
      end
      PH_GAP: begin
        ph_step = PH_LON;
      end
      PH_LON: begin
        res.vld  = 1'b1;
        res.ch   = rx_byte;
        res.line = LINE_LON;
        res.last = (rx_byte == CH_E);
        done     = (rx_byte == CH_E);
      end
      default: begin
        // hunting: length test only once the header completes
        ph_step  = PH_HUNT;
        chk_len  = 1'b0;
        cnt_step = 8'd0;
        if (hdr_hit) begin
          cnt_step = byte_count + 8'd1;
          if (cnt_step == HDR_LEN) begin
            ph_step = PH_SKIP1;
            chk_len = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    if (done || (chk_len && (cnt_step >= frame_length))) begin
      phase_nxt = PH_HUNT;
      count_nxt = 8'd0;
    end else begin
      phase_nxt = ph_step;
      count_nxt = cnt_step;
    end
  end

endmodule

// ===== design/gga_position_field_extractor_unit.sv =====
// An accepted input byte is registered, parsed, and its result beat registered on out_*.
// Throughput: one byte per cycle; a byte is taken every cycle unless the
// result register holds a beat the sink has not taken.
// Reset (rst_n low, synchronous): hunting the header, count zero,
// frame_length back to 65, both stages empty.
module gga_position_field_extractor_unit
  import gpfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser,  // [0] line_sel
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data // frame_length
);

  logic [7:0] frame_len_r;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  res_t       res;
  logic       out_vld_r;
  logic [7:0] out_char_r;
  logic       out_line_r;
  logic       out_last_r;
  logic       adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  gpfe_parser u_parser (
    .phase        (phase_r),
    .byte_count   (count_r),
    .rx_byte      (in_byte_r),
    .frame_length (frame_len_r),
    .phase_nxt    (phase_nxt),
    .count_nxt    (count_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      frame_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= 8'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_char_r <= res.ch;
      out_line_r <= res.line;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_line_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/gpfe_checker.sv =====
module gpfe_checker
  import gpfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_lat_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && (out_tuser == LINE_LAT) |-> out_tdata == CH_N)
    else $error("latitude last beat is not N");

  a_lon_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && (out_tuser == LINE_LON) |-> out_tdata == CH_E)
    else $error("longitude last beat is not E");

  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == LINE_LAT) && (out_tdata == CH_N) |-> out_tlast)
    else $error("N on latitude line without last");

endmodule

bind gga_position_field_extractor_unit gpfe_checker u_gpfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import gpfe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 600;
  // "$GPGGA", first character in the low byte
  localparam logic [47:0] GGA_HDR = 48'h414747504724;

  typedef struct packed {
    logic [7:0] ch;
    logic       sel;
    logic       last;
  } pos_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  pos_beat_t  pending_beats[$];
  phase_t     phase_shadow;
  logic [7:0] count_shadow;
  logic [7:0] frame_len_shadow;
  int         mismatches = 0;
  int         framed_beats = 0;
  int         cycle_count = 0;
  bit         in_idle_on = 1'b1;
  bit         out_idle_on = 1'b1;

  gga_position_field_extractor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Returns 1 when the byte yields a position beat.
  function automatic logic predict_position(input logic [7:0] c, output pos_beat_t beat);
    logic emit;
    logic done;
    emit = 1'b0;
    done = 1'b0;
    beat = '0;
    if (phase_shadow == PH_HUNT) begin
      if (count_shadow < HDR_LEN && c == GGA_HDR[{count_shadow[2:0], 3'b000} +: 8]) begin
        count_shadow = count_shadow + 8'd1;
        if (count_shadow == HDR_LEN) phase_shadow = PH_SKIP1;
      end else begin
        count_shadow = 8'd0;
      end
      if (phase_shadow == PH_HUNT) return 1'b0;
    end else begin
      if (count_shadow != CNT_MAX) count_shadow = count_shadow + 8'd1;
      case (phase_shadow)
        PH_SKIP1: if (c == CH_COMMA) phase_shadow = PH_SKIP2;
        PH_SKIP2: if (c == CH_COMMA) phase_shadow = PH_LAT;
        PH_LAT: begin
          beat = '{ch: c, sel: LINE_LAT, last: (c == CH_N)};
          emit = 1'b1;
          if (c == CH_N) phase_shadow = PH_GAP;
        end
        PH_GAP: phase_shadow = PH_LON;
        default: begin
          beat = '{ch: c, sel: LINE_LON, last: (c == CH_E)};
          emit = 1'b1;
          done = (c == CH_E);
        end
      endcase
    end
    if (done || count_shadow >= frame_len_shadow) begin
      phase_shadow = PH_HUNT;
      count_shadow = 8'd0;
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got 0x%02h, expected 0x%02h", what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    pos_beat_t beat;
    gap = in_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    if (predict_position(b, beat)) pending_beats.push_back(beat);
    framed_beats++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_frame_length(input logic [7:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_len_shadow = v;
  endtask

  function automatic logic [7:0] field_char(input logic [7:0] avoid);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) != 0) c = 8'h30 + 8'($urandom_range(0, 10));
      else c = 8'($urandom_range(0, 255));
    end while (c == avoid);
    return c;
  endfunction

  task automatic send_sentence();
    int kind;
    int bad_pos;
    int lat_len;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    bad_pos = $urandom_range(0, 5);
    in_idle_on = ($urandom_range(0, 3) != 0);
    out_idle_on = ($urandom_range(0, 3) != 0);
    if (kind == 8) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 9) begin
      for (int i = 0; i < bad_pos; i++) send_byte(GGA_HDR[8*i +: 8]);
      send_byte(field_char(GGA_HDR[8*bad_pos +: 8]));
      return;
    end
    for (int i = 0; i < 6; i++) begin
      b = GGA_HDR[8*i +: 8];
      if (kind == 7 && i == bad_pos) b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
    repeat ($urandom_range(0, 3)) send_byte(field_char(CH_COMMA));
    send_byte(CH_COMMA);
    repeat ($urandom_range(0, 3)) send_byte(field_char(CH_COMMA));
    send_byte(CH_COMMA);
    lat_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
    repeat (lat_len) send_byte(field_char(CH_N));
    send_byte(CH_N);
    send_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 6)) send_byte(field_char(CH_E));
    if (kind != 6) send_byte(CH_E);
  endtask

  always @(posedge clk) begin : beat_check
    pos_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with none pending", out_tdata, 8'h00);
      end else begin
        want = pending_beats.pop_front();
        if (out_tdata !== want.ch) report_mismatch("out_char", out_tdata, want.ch);
        if (out_tuser !== want.sel) report_mismatch("line_sel", 8'(out_tuser), 8'(want.sel));
        if (out_tlast !== want.last) report_mismatch("last", 8'(out_tlast), 8'(want.last));
      end
    end
  end

  initial begin : sink_stall
    int stall;
    forever begin
      stall = out_idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$G$");
    send_text("$GPGGA,1,2N;4E");
  endtask

  task automatic test_length_cut();
    set_frame_length(8'd11);
    send_text("$GPGGA,,123N");
  endtask

  task automatic test_short_length();
    set_frame_length(8'd6);
    send_text("$GPGGA,,N,E");
  endtask

  task automatic test_random_sentences();
    logic [7:0] len;
    for (int r = 0; r < 9; r++) begin
      case (r)
        0: len = 8'd255;
        1: len = 8'd7;
        2: len = 8'd0;
        3: len = 8'd40;
        4: len = 8'd65;
        default: len = 8'($urandom_range(7, 255));
      endcase
      set_frame_length(len);
      while (framed_beats < (r + 1) * (RANDOM_BEATS / 9)) send_sentence();
    end
  endtask

  initial begin
    frame_len_shadow = FRAME_LEN_RST;
    phase_shadow = PH_HUNT;
    count_shadow = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_hunt();
    test_length_cut();
    test_short_length();
    framed_beats = 0;
    test_random_sentences();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
